/* hdl/servo_angle_pwm_serializer_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the servo angle PWM serializer
// Immediate-implication and next-cycle-implication checks, clocked on clk and
// disabled during reset. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef SERVO_ANGLE_PWM_SERIALIZER_TOP_ASSERT_SVH
`define SERVO_ANGLE_PWM_SERIALIZER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Check cons in the same cycle as ante.
`define SAPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check cons in the cycle after ante.
`define SAPS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SAPS_ASSERT_IMP(lbl, ante, cons, msg)
`define SAPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/saps_pkg.sv */
// ----------------------------------------------------------------------------
// saps_pkg
// Widths, constants and codes of the servo angle PWM serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package saps_pkg;

	localparam int KIND_W      = 2;
	localparam int CH_W        = 4;
	localparam int ANG_W       = 11;
	localparam int USEC_W      = 15;
	localparam int BYTE_W      = 8;
	localparam int GRAY_W      = 12;

	localparam int ADIFF_W     = ANG_W + 1;       // angle difference, signed
	localparam int UDIFF_W     = USEC_W + 1;      // microsecond difference, signed
	localparam int PROD_W      = ADIFF_W + UDIFF_W;
	localparam int PMAG_W      = PROD_W - 1;      // product magnitude
	localparam int AMAG_W      = ANG_W;           // angle range magnitude
	localparam int FIVE_REM_W  = 3;               // remainder of a divide by five
	localparam int BIDX_W      = 5;               // byte index of a channel word

	localparam int CHANNELS        = 16;
	localparam int STORE_BYTES_DEF = 24;

	localparam int USEC_OFFSET = 80;
	localparam int DIV_CONST   = 5;
	localparam int COUNT_BIAS  = 112;

	typedef enum logic [KIND_W-1:0] {
		KIND_SET    = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_UPDATE = 2'd2,
		KIND_BLANK  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MUL,
		S_ABS,
		S_DIV,
		S_WORD,
		S_RING,
		S_SEND
	} state_t;

endpackage

`default_nettype wire

/* hdl/servo_angle_pwm_serializer_top.sv */
// ----------------------------------------------------------------------------
// servo_angle_pwm_serializer_top
// Servo angle to grayscale word mapper with a byte-serial store shifter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one item per command: set a
//   channel angle, clear the store, send the store, or report a blank event.
//   Output channel (out_valid/out_ready) delivers result items: 24 store
//   bytes (STORE_BYTES), highest byte first, for a send, or a single item
//   for a refused send or a blank event, flagged by last on the final one.
//   One item is worked on at a time; in_ready is high only while idle.
//   A set item passes through a multiply step, a magnitude step, a
//   bit-serial divider (one quotient bit per cycle), a word step and
//   one full turn of the byte ring.
//   A send makes one ring step per delivered byte.
//   A stalled receiver holds the output register and freezes the ring;
//   a single result item waiting in the output register does not stop
//   the next input item from being taken.
//   Reset clears the store to zero in one step and sets the latch flag;
//   no clearing pass follows.
// ----------------------------------------------------------------------------
`default_nettype none
`include "servo_angle_pwm_serializer_top_assert.svh"

module servo_angle_pwm_serializer_top
	import saps_pkg::*;
#(
	parameter int STORE_BYTES = STORE_BYTES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [KIND_W-1:0]        kind,
	input  wire logic [CH_W-1:0]          channel,
	input  wire logic signed [ANG_W-1:0]  angle,
	input  wire logic signed [ANG_W-1:0]  min_angle,
	input  wire logic signed [ANG_W-1:0]  max_angle,
	input  wire logic [USEC_W-1:0]        min_usec,
	input  wire logic [USEC_W-1:0]        max_usec,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [BYTE_W-1:0]             data_byte,
	output logic                          last,
	output logic                          sent,
	output logic                          latch
);

	localparam int IDX_W  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int CMP_W  = (IDX_W > BIDX_W + 1) ? IDX_W : BIDX_W + 1;
	localparam int BCNT_W = $clog2(PMAG_W);
	localparam logic [FIVE_REM_W:0] FIVE = (FIVE_REM_W + 1)'(DIV_CONST);

	// control state
	state_t              state_q, state_d;
	logic                latch_pending_q;
	logic [IDX_W-1:0]    bidx_q;
	logic [BCNT_W-1:0]   bitcnt_q;
	logic                out_valid_q;

	// captured item
	kind_t                     kind_q;
	logic [CH_W-1:0]           ch_q;
	logic signed [ANG_W-1:0]   ang_q, amin_q, amax_q;
	logic [USEC_W-1:0]         umin_q, umax_q;

	// arithmetic registers
	logic signed [PROD_W-1:0]  prod_q;
	logic                      psign_q, asign_q, az_q, usign_q;
	logic [AMAG_W-1:0]         amag_q;
	logic [PMAG_W-1:0]         pm_q, um_q, um_pre_q;
	logic [AMAG_W-1:0]         rem_q;
	logic [FIVE_REM_W-1:0]     rem5_q, remu_q;
	logic [GRAY_W-1:0]         q5_q, qu_q, word_q;

	// output register
	logic [BYTE_W-1:0]         data_byte_q;
	logic                      last_q, sent_q, latch_q;

	// byte ring, head at the top
	logic [BYTE_W-1:0]         ring_q [STORE_BYTES];
	logic [BYTE_W-1:0]         head, head_new;

	// control decode
	logic                out_free;
	logic                out_load, rot, rot_mod, ring_clr, latch_set, latch_clr;
	logic                bidx_load;
	logic [BYTE_W-1:0]   ob_data;
	logic                ob_last, ob_sent, ob_latch;

	// channel placement
	logic [BIDX_W-1:0]   b_idx;
	logic                wr_ok, hit_lo, hit_hi;

	// datapath combinational terms
	logic signed [ADIFF_W-1:0] adiff, arange;
	logic signed [UDIFF_W-1:0] udiff, udm;
	logic [ADIFF_W-1:0]        arange_neg;
	logic [UDIFF_W-1:0]        udm_neg;
	logic [PROD_W-1:0]         prod_neg;
	logic [AMAG_W:0]           trial;
	logic                      ge, qbit;
	logic [FIVE_REM_W:0]       t5, tu;
	logic                      ge5, geu;
	logic [GRAY_W-1:0]         d1, d2, count;

	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign data_byte = data_byte_q;
	assign last      = last_q;
	assign sent      = sent_q;
	assign latch     = latch_q;

	assign head = ring_q[STORE_BYTES-1];

	// word of channel n starts at byte n * 3 / 2
	assign b_idx  = BIDX_W'(ch_q) + BIDX_W'(ch_q[CH_W-1:1]);
	assign wr_ok  = (32'(ch_q) < CHANNELS) && (32'(b_idx) + 32'd1 < STORE_BYTES);
	assign hit_lo = (CMP_W'(bidx_q) == CMP_W'(b_idx));
	assign hit_hi = (CMP_W'(bidx_q) == CMP_W'(b_idx) + CMP_W'(1));

	// merge the new word into the byte passing the head
	always_comb begin
		head_new = head;
		if (rot_mod && wr_ok) begin
			if (hit_lo) begin
				head_new = ch_q[0] ? {word_q[3:0], head[3:0]} : word_q[7:0];
			end else if (hit_hi) begin
				head_new = ch_q[0] ? word_q[11:4] : {head[7:4], word_q[11:8]};
			end
		end
	end

	// next state and control
	always_comb begin
		state_d   = state_q;
		out_load  = 1'b0;
		ob_data   = '0;
		ob_last   = 1'b0;
		ob_sent   = 1'b0;
		ob_latch  = 1'b0;
		rot       = 1'b0;
		rot_mod   = 1'b0;
		ring_clr  = 1'b0;
		latch_set = 1'b0;
		latch_clr = 1'b0;
		bidx_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (kind_q)
					KIND_SET: state_d = S_MUL;
					KIND_CLEAR: begin
						ring_clr = 1'b1;
						state_d  = S_IDLE;
					end
					KIND_UPDATE: begin
						if (latch_pending_q) begin
							// refuse the send: one empty item
							if (out_free) begin
								out_load = 1'b1;
								ob_last  = 1'b1;
								state_d  = S_IDLE;
							end
						end else begin
							bidx_load = 1'b1;
							state_d   = S_SEND;
						end
					end
					KIND_BLANK: begin
						if (out_free) begin
							out_load  = 1'b1;
							ob_last   = 1'b1;
							ob_latch  = latch_pending_q;
							latch_clr = 1'b1;
							state_d   = S_IDLE;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_MUL: state_d = S_ABS;
			S_ABS: state_d = S_DIV;
			S_DIV: begin
				if (bitcnt_q == '0) state_d = S_WORD;
			end
			S_WORD: begin
				bidx_load = 1'b1;
				state_d   = wr_ok ? S_RING : S_IDLE;
			end
			S_RING: begin
				rot     = 1'b1;
				rot_mod = 1'b1;
				if (bidx_q == '0) state_d = S_IDLE;
			end
			S_SEND: begin
				if (out_free) begin
					out_load = 1'b1;
					ob_data  = head;
					ob_last  = (bidx_q == '0);
					ob_sent  = 1'b1;
					rot      = 1'b1;
					if (bidx_q == '0) begin
						latch_set = 1'b1;
						state_d   = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_pending_q <= 1'b1;
			out_valid_q     <= 1'b0;
			bidx_q          <= '0;
			bitcnt_q        <= '0;
		end else begin
			if (latch_set) begin
				latch_pending_q <= 1'b1;
			end else if (latch_clr) begin
				latch_pending_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (bidx_load) begin
				bidx_q <= IDX_W'(STORE_BYTES - 1);
			end else if (rot) begin
				bidx_q <= bidx_q - IDX_W'(1);
			end
			if (state_q == S_ABS) begin
				bitcnt_q <= BCNT_W'(PMAG_W - 1);
			end else if (state_q == S_DIV) begin
				bitcnt_q <= bitcnt_q - BCNT_W'(1);
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			data_byte_q <= ob_data;
			last_q      <= ob_last;
			sent_q      <= ob_sent;
			latch_q     <= ob_latch;
		end
	end

	// byte ring: rotate toward the head, clear all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_BYTES; i++) ring_q[i] <= '0;
		end else if (ring_clr) begin
			for (int i = 0; i < STORE_BYTES; i++) ring_q[i] <= '0;
		end else if (rot) begin
			ring_q[0] <= head_new;
			for (int i = 1; i < STORE_BYTES; i++) ring_q[i] <= ring_q[i-1];
		end
	end

	// operand preparation
	assign adiff      = ADIFF_W'(ang_q) - ADIFF_W'(amin_q);
	assign arange     = ADIFF_W'(amax_q) - ADIFF_W'(amin_q);
	assign arange_neg = ADIFF_W'(0) - arange;
	assign udiff      = $signed({1'b0, umax_q}) - $signed({1'b0, umin_q});
	assign udm        = $signed({1'b0, umin_q}) - UDIFF_W'(USEC_OFFSET);
	assign udm_neg    = UDIFF_W'(0) - udm;
	assign prod_neg   = PROD_W'(0) - prod_q;

	// one quotient bit per cycle; the bit feeds the divide by five at once
	assign trial = {rem_q, pm_q[PMAG_W-1]};
	assign ge    = (trial >= {1'b0, amag_q});
	assign qbit  = ge && !az_q;
	assign t5    = {rem5_q, qbit};
	assign ge5   = (t5 >= FIVE);
	assign tu    = {remu_q, um_q[PMAG_W-1]};
	assign geu   = (tu >= FIVE);

	// truncate toward zero: divide magnitudes, then restore the sign
	assign d1    = usign_q ? (GRAY_W'(0) - qu_q) : qu_q;
	assign d2    = (psign_q ^ asign_q) ? (GRAY_W'(0) - q5_q) : q5_q;
	assign count = d1 + d2 + GRAY_W'(COUNT_BIAS);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q <= kind_t'(kind);
			ch_q   <= channel;
			ang_q  <= angle;
			amin_q <= min_angle;
			amax_q <= max_angle;
			umin_q <= min_usec;
			umax_q <= max_usec;
		end
		case (state_q)
			S_MUL: begin
				prod_q   <= PROD_W'(adiff) * PROD_W'(udiff);
				asign_q  <= arange[ADIFF_W-1];
				amag_q   <= arange[ADIFF_W-1] ? arange_neg[AMAG_W-1:0]
				                              : arange[AMAG_W-1:0];
				az_q     <= (arange == '0);
				usign_q  <= udm[UDIFF_W-1];
				um_pre_q <= PMAG_W'(udm[UDIFF_W-1] ? udm_neg[USEC_W-1:0]
				                                   : udm[USEC_W-1:0]);
			end
			S_ABS: begin
				psign_q <= prod_q[PROD_W-1];
				pm_q    <= prod_q[PROD_W-1] ? prod_neg[PMAG_W-1:0] : prod_q[PMAG_W-1:0];
				um_q    <= um_pre_q;
				rem_q   <= '0;
				rem5_q  <= '0;
				remu_q  <= '0;
				q5_q    <= '0;
				qu_q    <= '0;
			end
			S_DIV: begin
				pm_q   <= {pm_q[PMAG_W-2:0], 1'b0};
				rem_q  <= ge ? AMAG_W'(trial - {1'b0, amag_q}) : trial[AMAG_W-1:0];
				rem5_q <= ge5 ? FIVE_REM_W'(t5 - FIVE) : t5[FIVE_REM_W-1:0];
				q5_q   <= {q5_q[GRAY_W-2:0], ge5};
				um_q   <= {um_q[PMAG_W-2:0], 1'b0};
				remu_q <= geu ? FIVE_REM_W'(tu - FIVE) : tu[FIVE_REM_W-1:0];
				qu_q   <= {qu_q[GRAY_W-2:0], geu};
			end
			S_WORD: begin
				// store the negated count, wrapped to the word width
				word_q <= GRAY_W'(0) - count;
			end
			default: ;
		endcase
	end

	`SAPS_ASSERT_NXT(a_send_end_sets_latch, state_q == S_SEND && out_free && bidx_q == '0, latch_pending_q && state_q == S_IDLE, "send end did not set latch flag")
	`SAPS_ASSERT_IMP(a_sent_latch_excl, out_valid_q, !(sent_q && latch_q), "sent and latch both set")
	`SAPS_ASSERT_IMP(a_single_is_last, out_valid_q && !sent_q, last_q, "single result item without last")
	`SAPS_ASSERT_IMP(a_div_rem_bound, state_q == S_DIV && !az_q, rem_q < amag_q, "divider remainder out of range")
	`SAPS_ASSERT_IMP(a_five_rem_bound, state_q == S_DIV, rem5_q < FIVE_REM_W'(DIV_CONST) && remu_q < FIVE_REM_W'(DIV_CONST), "divide by five remainder out of range")

endmodule

`default_nettype wire

/* dv/tb_servo_angle_pwm_serializer_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_angle_pwm_serializer_top
// Self-checking bench for the servo angle PWM serializer. It drives set, clear,
// update and blank commands over the input handshake and keeps its own copy
// of the grayscale store and the latch flag to predict each result item. Every
// delivered byte, refused update and blank report is compared field by field.
// ----------------------------------------------------------------------------

module tb_servo_angle_pwm_serializer_top;
	import saps_pkg::*;

	localparam int NBYTES        = STORE_BYTES_DEF;
	localparam int IDLE_PCT      = 31;    // chance of an idle cycle on either side
	localparam int HOLD_LEN      = 300;   // long receiver hold-off, in cycles
	localparam int SETTLE_CYCLES = 120;   // room for a trailing set command to finish
	localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all

	// One command as it sits on the input port.
	typedef struct packed {
		kind_t              kind;
		logic [CH_W-1:0]    channel;
		logic [ANG_W-1:0]   angle;
		logic [ANG_W-1:0]   min_angle;
		logic [ANG_W-1:0]   max_angle;
		logic [USEC_W-1:0]  min_usec;
		logic [USEC_W-1:0]  max_usec;
	} servo_cmd_t;

	// One result item as it leaves the output port.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              sent;
		logic              latch;
	} out_rec_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [KIND_W-1:0]     kind;
	logic [CH_W-1:0]       channel;
	logic [ANG_W-1:0]      angle;
	logic [ANG_W-1:0]      min_angle;
	logic [ANG_W-1:0]      max_angle;
	logic [USEC_W-1:0]     min_usec;
	logic [USEC_W-1:0]     max_usec;
	logic                  out_valid;
	logic                  out_ready;
	logic [BYTE_W-1:0]     data_byte;
	logic                  last;
	logic                  sent;
	logic                  latch;

	// Shadow of the block: packed grayscale bytes and the latch-pending flag.
	logic [BYTE_W-1:0]     gray_img [NBYTES];
	bit                    latch_armed;

	// Result items the block still owes, oldest first.
	out_rec_t              outgoing_q[$];

	int                    errors;
	int                    items_sent;
	int                    cmds_seen [4];
	int                    outs_checked;
	int                    dumps_seen;
	int                    refusals_seen;
	int                    idle_run;
	bit                    src_idle_en;
	bit                    sink_idle_en;
	int unsigned           hold_asked;
	int unsigned           hold_taken;

	servo_angle_pwm_serializer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.channel   (channel),
		.angle     (angle),
		.min_angle (min_angle),
		.max_angle (max_angle),
		.min_usec  (min_usec),
		.max_usec  (max_usec),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data_byte (data_byte),
		.last      (last),
		.sent      (sent),
		.latch     (latch)
	);

	// 10 ns clock, low phase first so the first edge seen is a falling one.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Advance the shadow state by one accepted command and queue the result
	// items it causes. Arithmetic is held in 64 bits so nothing can overflow;
	// SystemVerilog division truncates toward zero, as the block must.
	task automatic apply_servo_cmd(input servo_cmd_t c);
		longint ang, amin, amax, umin, umax, span, offset, cnt, raw;
		logic [GRAY_W-1:0] word;
		int b;
		out_rec_t r;
		case (c.kind)
			KIND_SET: begin
				ang  = $signed(c.angle);
				amin = $signed(c.min_angle);
				amax = $signed(c.max_angle);
				umin = c.min_usec;
				umax = c.max_usec;
				span = amax - amin;
				// Equal angle limits: no offset at all.
				offset = (span != 0) ? ((ang - amin) * (umax - umin)) / span : 0;
				cnt = (umin - USEC_OFFSET) / DIV_CONST + COUNT_BIAS + offset / DIV_CONST;
				// Out-of-range counts wrap: keep the low twelve bits only.
				raw = 4096 - cnt;
				word = raw[GRAY_W-1:0];
				// A 4-bit channel always lands inside a 16-channel store.
				b = (int'(c.channel) * 12) / 8;
				if (!c.channel[0]) begin
					gray_img[b]     = word[7:0];
					gray_img[b + 1] = {gray_img[b + 1][7:4], word[11:8]};
				end else begin
					gray_img[b]     = {word[3:0], gray_img[b][3:0]};
					gray_img[b + 1] = word[11:4];
				end
			end
			KIND_CLEAR: begin
				foreach (gray_img[i])
					gray_img[i] = '0;
			end
			KIND_UPDATE: begin
				if (latch_armed) begin
					// Refused: one bare item, store left alone.
					r = '{data: '0, last: 1'b1, sent: 1'b0, latch: 1'b0};
					outgoing_q.push_back(r);
				end else begin
					for (int k = 0; k < NBYTES; k++) begin
						r.data  = gray_img[NBYTES - 1 - k];
						r.last  = (k == NBYTES - 1);
						r.sent  = 1'b1;
						r.latch = 1'b0;
						outgoing_q.push_back(r);
					end
					latch_armed = 1'b1;
				end
			end
			default: begin
				r = '{data: '0, last: 1'b1, sent: 1'b0, latch: latch_armed};
				outgoing_q.push_back(r);
				latch_armed = 1'b0;
			end
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic note_mismatch(input string msg);
		errors++;
		if (errors <= 50)
			$display("ERROR %0t: %s", $realtime, msg);
	endtask

	// Sample both handshakes on the rising edge. Check the output first: a
	// result in this cycle always belongs to an earlier command.
	always @(posedge clk) begin : track
		out_rec_t want;
		servo_cmd_t c;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (outgoing_q.size() == 0) begin
					note_mismatch($sformatf("unexpected result item, data_byte %02h last %b",
						data_byte, last));
				end else begin
					want = outgoing_q.pop_front();
					if (want.data !== data_byte)
						note_mismatch($sformatf("item %0d data_byte: want %02h got %02h",
							outs_checked, want.data, data_byte));
					if (want.last !== last)
						note_mismatch($sformatf("item %0d last: want %b got %b",
							outs_checked, want.last, last));
					if (want.sent !== sent)
						note_mismatch($sformatf("item %0d sent: want %b got %b",
							outs_checked, want.sent, sent));
					if (want.latch !== latch)
						note_mismatch($sformatf("item %0d latch: want %b got %b",
							outs_checked, want.latch, latch));
					if (want.sent && want.last)
						dumps_seen++;
				end
				outs_checked++;
			end
			if (in_valid && in_ready) begin
				c.kind      = kind_t'(kind);
				c.channel   = channel;
				c.angle     = angle;
				c.min_angle = min_angle;
				c.max_angle = max_angle;
				c.min_usec  = min_usec;
				c.max_usec  = max_usec;
				if (c.kind == KIND_UPDATE && latch_armed)
					refusals_seen++;
				cmds_seen[c.kind]++;
				apply_servo_cmd(c);
			end
		end
	end

	// Watchdog: end the run if no item moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_run <= 0;
		end else if (idle_run >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("servo_angle_pwm_serializer_top: mismatch");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver
	// ------------------------------------------------------------------------

	// Drive out_ready at the falling edge. A hold request from a test forces a
	// long stretch low; otherwise idle at random while idling is enabled.
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asked != hold_taken) begin
				hold_taken = hold_asked;
				stall_left = HOLD_LEN;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (sink_idle_en && $urandom_range(99) < IDLE_PCT) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------

	function automatic servo_cmd_t make_cmd(input kind_t k, input int ch, input int ang,
			input int amin, input int amax, input int umin, input int umax);
		servo_cmd_t c;
		c.kind      = k;
		c.channel   = CH_W'(ch);
		c.angle     = ANG_W'(ang);
		c.min_angle = ANG_W'(amin);
		c.max_angle = ANG_W'(amax);
		c.min_usec  = USEC_W'(umin);
		c.max_usec  = USEC_W'(umax);
		return c;
	endfunction

	// Random set command: mostly a plausible servo, sometimes equal angle
	// limits, sometimes every field at random over its full width.
	function automatic servo_cmd_t rand_set();
		int lo, hi, pick;
		servo_cmd_t c;
		pick = $urandom_range(99);
		lo = -$urandom_range(180);
		hi = $urandom_range(180);
		c = make_cmd(KIND_SET, $urandom_range(15), lo - 20 + $urandom_range(hi - lo + 40),
			lo, hi, $urandom_range(400, 1200), $urandom_range(1800, 2600));
		if (pick < 10) begin
			c.max_angle = c.min_angle;
		end else if (pick < 35) begin
			c.angle     = ANG_W'($urandom_range(2047));
			c.min_angle = ANG_W'($urandom_range(2047));
			c.max_angle = ANG_W'($urandom_range(2047));
			c.min_usec  = USEC_W'($urandom_range(32767));
			c.max_usec  = USEC_W'($urandom_range(32767));
		end
		return c;
	endfunction

	// Offer one command at the falling edge and hold it until it is taken.
	// Valid is lowered only when an idle gap is chosen before the next one.
	task automatic send_item(input servo_cmd_t c);
		while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		kind      <= c.kind;
		channel   <= c.channel;
		angle     <= c.angle;
		min_angle <= c.min_angle;
		max_angle <= c.max_angle;
		min_usec  <= c.min_usec;
		max_usec  <= c.max_usec;
		in_valid  <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Well-formed refresh: maybe a clear, a few channel sets, a blank that
	// releases the latch, then an update that dumps the whole store.
	task automatic send_frame(output int n);
		int sets;
		sets = $urandom_range(1, 4);
		n = sets + 2;
		if ($urandom_range(9) == 0) begin
			send_item(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0));
			n++;
		end
		repeat (sets)
			send_item(rand_set());
		send_item(make_cmd(KIND_BLANK, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(KIND_UPDATE, 0, 0, 0, 0, 0, 0));
	endtask

	// Drop valid and hold off until every owed result has come out.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (outgoing_q.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Latch starts pending: the first update is refused, the first blank
	// pulses, the second does not, and the store dumps as all zeros.
	task automatic test_after_reset();
		send_item(make_cmd(KIND_UPDATE, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(KIND_BLANK, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(KIND_BLANK, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(KIND_UPDATE, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(KIND_UPDATE, 0, 0, 0, 0, 0, 0));
	endtask

	// Field extremes, reversed and equal angle limits, counts that wrap both
	// ways, even and odd channels at both ends of the store.
	task automatic test_field_extremes();
		send_item(make_cmd(KIND_SET, 0, -1024, -1024, 1023, 0, 32767));
		send_item(make_cmd(KIND_SET, 15, 1023, 1023, -1024, 32767, 0));
		send_item(make_cmd(KIND_SET, 7, 1023, 0, 0, 20000, 20000));
		send_item(make_cmd(KIND_SET, 8, 0, -90, 90, 0, 0));
		send_item(make_cmd(KIND_SET, 1, -1024, 1023, -1024, 32767, 32767));
		send_item(make_cmd(KIND_SET, 14, 1023, -90, 90, 544, 2400));
		send_item(make_cmd(KIND_SET, 6, -1024, -90, 90, 544, 2400));
		send_item(make_cmd(KIND_BLANK, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(KIND_UPDATE, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(KIND_BLANK, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(KIND_UPDATE, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(KIND_SET, 15, 0, -90, 90, 1000, 2000));
		send_item(make_cmd(KIND_UPDATE, 0, 0, 0, 0, 0, 0));
	endtask

	// Back-to-back traffic with no idling on either side.
	task automatic test_back_to_back(input int target);
		int done, n;
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		done = 0;
		while (done < target) begin
			send_frame(n);
			done += n;
		end
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	// Hold the receiver off for a long stretch while commands keep coming,
	// so a dump backs up into the block and the input stalls.
	task automatic test_output_backpressure();
		hold_asked++;
		send_item(make_cmd(KIND_BLANK, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(KIND_UPDATE, 0, 0, 0, 0, 0, 0));
		send_item(rand_set());
		send_item(rand_set());
		send_item(make_cmd(KIND_BLANK, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(KIND_UPDATE, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(KIND_UPDATE, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(KIND_BLANK, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(KIND_UPDATE, 0, 0, 0, 0, 0, 0));
	endtask

	// Let the block drain completely between refreshes.
	task automatic test_drain_pause();
		int n;
		repeat (2) begin
			send_frame(n);
			wait_for_drain();
		end
	endtask

	// Mostly well-formed refreshes with random content; the rest is noise
	// with every field random, including refused updates and stray blanks.
	task automatic test_random_traffic(input int target);
		int done, n;
		done = 0;
		while (done < target) begin
			if ($urandom_range(99) < 80) begin
				send_frame(n);
				done += n;
			end else begin
				send_item(make_cmd(kind_t'($urandom_range(3)), $urandom_range(15),
					$urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
					$urandom_range(32767), $urandom_range(32767)));
				done++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin : run
		// Drive every input to a known value before the first edge.
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		kind         = KIND_SET;
		channel      = '0;
		angle        = '0;
		min_angle    = '0;
		max_angle    = '0;
		min_usec     = '0;
		max_usec     = '0;
		errors       = 0;
		items_sent   = 0;
		outs_checked = 0;
		dumps_seen   = 0;
		refusals_seen = 0;
		hold_asked   = 0;
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		cmds_seen    = '{default: 0};
		latch_armed  = 1'b1;
		foreach (gray_img[i])
			gray_img[i] = '0;

		// Hold reset low, then release it on a falling edge.
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_after_reset();
		test_field_extremes();
		test_back_to_back(40);
		test_output_backpressure();
		test_drain_pause();
		test_random_traffic(380);

		// Drain, then give a trailing set command time to finish quietly.
		wait_for_drain();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (outgoing_q.size() != 0)
			note_mismatch($sformatf("%0d result items never arrived", outgoing_q.size()));

		$display("covered %0d commands: %0d set, %0d clear, %0d update, %0d blank",
			items_sent, cmds_seen[KIND_SET], cmds_seen[KIND_CLEAR],
			cmds_seen[KIND_UPDATE], cmds_seen[KIND_BLANK]);
		$display("checked %0d result items: %0d full store dumps, %0d refused updates",
			outs_checked, dumps_seen, refusals_seen);
		if (errors == 0)
			$display("servo_angle_pwm_serializer_top: match");
		else
			$display("servo_angle_pwm_serializer_top: mismatch");
		$finish;
	end

endmodule
